@@ hw/rtl/c2p_pkg.sv @@
// c2p_pkg: widths, the payload struct and the arctangent table function
// shared by the cartesian_to_polar_core pipeline; no dependencies
`default_nettype none
package c2p_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int ANGLE_FRAC        = 40;
  localparam int MAX_STAGES        = 40;
  localparam int COORD_W           = 32;
  localparam int RADIUS_W          = 48;
  localparam int ANGLE_W           = 25;
  localparam int VEC_W             = 64;
  localparam int PHASE_W           = 48;
  localparam int NORM_MSB          = 59;

  typedef struct packed {
    logic signed [VEC_W-1:0]   xv;
    logic signed [VEC_W-1:0]   yv;
    logic signed [PHASE_W-1:0] z;
    logic [VEC_W-1:0]          s;
    logic                      axz;
    logic                      ayz;
    logic                      xpos;
    logic                      xneg;
    logic                      ypos;
    logic                      yneg;
    logic                      last;
  } c2p_work_t;

  // arctan(2^-i) in radians, q62
  function automatic logic [63:0] atan_pow2_q62(int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned e;
    acc = '0;
    for (int unsigned k = 0; k < 62; k++) begin
      e = i * (2 * k + 1);
      if (e < 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k[0]) acc = acc - term;
        else acc = acc + term;
      end
    end
    return acc;
  endfunction

  // arctan(1/3) in radians, q62
  function automatic logic [63:0] atan_third_q62();
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] term;
    acc = '0;
    p = (64'd1 << 62) / 64'd3;
    for (int unsigned k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = p / 64'(2 * k + 1);
        if (k[0]) acc = acc - term;
        else acc = acc + term;
        p = p / 64'd9;
      end
    end
    return acc;
  endfunction

  // arctan(2^-i) in degrees with ANGLE_FRAC fraction bits
  function automatic logic signed [PHASE_W-1:0] atan_deg(int unsigned i);
    logic [63:0] qp;
    logic [63:0] rem;
    logic [63:0] q;
    qp  = atan_pow2_q62(1) + atan_third_q62();
    rem = '0;
    q   = '0;
    if (i == 0) return PHASE_W'(64'd45 << ANGLE_FRAC);
    if (i >= MAX_STAGES) return '0;
    rem = atan_pow2_q62(i);
    for (int unsigned b = 0; b < 46; b++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= qp) begin
        rem = rem - qp;
        q = q | 64'd1;
      end
    end
    return PHASE_W'((q * 64'd45 + 64'd32) >> 6);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/c2p_in_if.sv @@
// c2p_in_if: request channel carrying one coordinate pair
// depends on c2p_pkg
`default_nettype none
interface c2p_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [c2p_pkg::COORD_W-1:0]   x_coord;
  logic signed [c2p_pkg::COORD_W-1:0]   y_coord;
  logic                                 last_in;

  modport source(output valid, output x_coord, output y_coord, output last_in, input ready);
  modport sink(input valid, input x_coord, input y_coord, input last_in, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/c2p_out_if.sv @@
// c2p_out_if: result channel carrying radius, angle and last flag
// depends on c2p_pkg
`default_nettype none
interface c2p_out_if;
  logic                            valid;
  logic                            ready;
  logic [c2p_pkg::RADIUS_W-1:0]    radius;
  logic [c2p_pkg::ANGLE_W-1:0]     angle_deg;
  logic                            last_out;

  modport source(output valid, output radius, output angle_deg, output last_out, input ready);
  modport sink(input valid, input radius, input angle_deg, input last_out, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/c2p_front.sv @@
// c2p_front: absolute values, squares, sum of squares and normalizing shift
// four register stages; depends on c2p_pkg and c2p_in_if
`default_nettype none
module c2p_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  c2p_in_if.sink               in_if,
  output c2p_pkg::c2p_work_t   work_o,
  output logic                 valid_o,
  input  wire logic            ready_i
);
  import c2p_pkg::*;

  typedef struct packed {
    logic axz;
    logic ayz;
    logic xpos;
    logic xneg;
    logic ypos;
    logic yneg;
    logic last;
  } c2p_flags_t;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [COORD_W-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  c2p_flags_t         f1_r, f2_r, f3_r;
  logic [VEC_W-1:0]   sqx2_r, sqy2_r, s3_r;
  logic [COORD_W-1:0] m2_r;
  logic [5:0]         sh3_r;
  c2p_work_t          w4_r;

  logic [COORD_W-1:0] ax_nxt, ay_nxt;
  c2p_flags_t         f_nxt;
  logic [5:0]         msb_nxt;

  assign rdy4 = !v4_r || ready_i;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;
  assign valid_o = v4_r;
  assign work_o = w4_r;

  always_comb begin
    ax_nxt = in_if.x_coord[COORD_W-1] ? (~in_if.x_coord + 1'b1) : in_if.x_coord;
    ay_nxt = in_if.y_coord[COORD_W-1] ? (~in_if.y_coord + 1'b1) : in_if.y_coord;
    f_nxt.axz  = (in_if.x_coord == '0);
    f_nxt.ayz  = (in_if.y_coord == '0);
    f_nxt.xneg = in_if.x_coord[COORD_W-1];
    f_nxt.yneg = in_if.y_coord[COORD_W-1];
    f_nxt.xpos = !in_if.x_coord[COORD_W-1] && (in_if.x_coord != '0);
    f_nxt.ypos = !in_if.y_coord[COORD_W-1] && (in_if.y_coord != '0);
    f_nxt.last = in_if.last_in;
  end

  // highest set bit of the larger magnitude
  always_comb begin
    msb_nxt = '0;
    for (int b = 0; b < COORD_W; b++) begin
      if (m2_r[b]) msb_nxt = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_if.valid) begin
      ax1_r <= ax_nxt;
      ay1_r <= ay_nxt;
      f1_r  <= f_nxt;
    end
    if (rdy2 && v1_r) begin
      sqx2_r <= VEC_W'(ax1_r) * VEC_W'(ax1_r);
      sqy2_r <= VEC_W'(ay1_r) * VEC_W'(ay1_r);
      m2_r   <= (ax1_r > ay1_r) ? ax1_r : ay1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      f2_r   <= f1_r;
    end
    if (rdy3 && v2_r) begin
      s3_r  <= sqx2_r + sqy2_r;
      sh3_r <= 6'(NORM_MSB) - msb_nxt;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      f3_r  <= f2_r;
    end
    if (rdy4 && v3_r) begin
      w4_r.xv   <= $signed(VEC_W'(ax3_r) << sh3_r);
      w4_r.yv   <= $signed(VEC_W'(ay3_r) << sh3_r);
      w4_r.z    <= '0;
      w4_r.s    <= s3_r;
      w4_r.axz  <= f3_r.axz;
      w4_r.ayz  <= f3_r.ayz;
      w4_r.xpos <= f3_r.xpos;
      w4_r.xneg <= f3_r.xneg;
      w4_r.ypos <= f3_r.ypos;
      w4_r.yneg <= f3_r.yneg;
      w4_r.last <= f3_r.last;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/c2p_stage.sv @@
// c2p_stage: a pipeline stage; cordic rotation and root digit, each gated by K
// depends on c2p_pkg
`default_nettype none
module c2p_stage #(
  parameter int K             = 0,
  parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF,
  parameter int FRACTION_BITS = c2p_pkg::FRACTION_BITS_DEF,
  parameter int SQ_STEPS      = c2p_pkg::COORD_W + c2p_pkg::FRACTION_BITS_DEF + 1,
  parameter int ROOT_W        = SQ_STEPS,
  parameter int REM_W         = SQ_STEPS + 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire c2p_pkg::c2p_work_t  w_i,
  input  wire logic [REM_W-1:0]    rem_i,
  input  wire logic [ROOT_W-1:0]   root_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  output c2p_pkg::c2p_work_t       w_o,
  output logic [REM_W-1:0]         rem_o,
  output logic [ROOT_W-1:0]        root_o,
  output logic                     valid_o,
  input  wire logic                ready_i
);
  import c2p_pkg::*;

  localparam logic signed [PHASE_W-1:0] ATAN = atan_deg(K);
  localparam int P    = SQ_STEPS - 1 - K;
  localparam bit HAS_PAIR = (P >= FRACTION_BITS + 1);
  localparam int PIDX = HAS_PAIR ? 2 * (P - FRACTION_BITS - 1) : 0;

  logic                valid_r;
  c2p_work_t           w_r, w_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt, remsh, trial;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [1:0]          pair;
  logic signed [VEC_W-1:0] dx, dy;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign w_o     = w_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

  always_comb begin
    w_nxt = w_i;
    dx = w_i.yv >>> K;
    dy = w_i.xv >>> K;
    if (K < CORDIC_STAGES) begin
      if (w_i.yv >= 0) begin
        w_nxt.xv = w_i.xv + dx;
        w_nxt.yv = w_i.yv - dy;
        w_nxt.z  = w_i.z + ATAN;
      end else begin
        w_nxt.xv = w_i.xv - dx;
        w_nxt.yv = w_i.yv + dy;
        w_nxt.z  = w_i.z - ATAN;
      end
    end
  end

  // one digit of the restoring square root
  always_comb begin
    pair = HAS_PAIR ? w_i.s[PIDX +: 2] : 2'b00;
    remsh = {rem_i[REM_W-3:0], pair};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, root_i, 2'b01};
    rem_nxt = rem_i;
    root_nxt = root_i;
    if (K < SQ_STEPS) begin
      if (remsh >= trial) begin
        rem_nxt  = remsh - trial;
        root_nxt = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = remsh;
        root_nxt = {root_i[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      w_r    <= w_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/c2p_back.sv @@
// c2p_back: quadrant unfolding, wrap, rounding and the output register
// four register stages; depends on c2p_pkg and c2p_out_if
`default_nettype none
module c2p_back #(
  parameter int FRACTION_BITS = c2p_pkg::FRACTION_BITS_DEF,
  parameter int ROOT_W        = c2p_pkg::COORD_W + c2p_pkg::FRACTION_BITS_DEF + 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire c2p_pkg::c2p_work_t w_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  c2p_out_if.source              out_if
);
  import c2p_pkg::*;

  localparam int TW    = 51;
  localparam int SHIFT = ANGLE_FRAC - FRACTION_BITS;
  localparam int AW    = TW - SHIFT;
  localparam logic signed [TW-1:0] FULL  = TW'(64'd360 << ANGLE_FRAC);
  localparam logic signed [TW-1:0] HALF  = TW'(64'd180 << ANGLE_FRAC);
  localparam logic signed [TW-1:0] RIGHT = TW'(64'd90 << ANGLE_FRAC);
  localparam logic [TW-1:0]        RND   = TW'(64'd1 << (SHIFT - 1));
  localparam logic [AW-1:0]        WRAP  = AW'(64'd360 << FRACTION_BITS);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [TW-1:0] t1_r, t2_r;
  logic [AW-1:0]        a3_r;
  logic                 zero1_r, zero2_r, zero3_r;
  logic                 last1_r, last2_r, last3_r;
  logic [RADIUS_W-1:0]  rad1_r, rad2_r, rad3_r;
  logic [RADIUS_W-1:0]  rad4_r;
  logic [ANGLE_W-1:0]   ang4_r;
  logic                 last4_r;

  logic signed [TW-1:0] phi, t_nxt, tw_nxt;
  logic [ROOT_W:0]      rsum;
  logic [AW-1:0]        a_nxt;

  assign rdy4 = !v4_r || out_if.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign ready_o = rdy1;

  assign out_if.valid     = v4_r;
  assign out_if.radius    = rad4_r;
  assign out_if.angle_deg = ang4_r;
  assign out_if.last_out  = last4_r;

  always_comb begin
    if (w_i.ayz) phi = '0;
    else if (w_i.axz) phi = RIGHT;
    else phi = TW'(w_i.z);
    if (w_i.xpos && !w_i.yneg) t_nxt = phi;
    else if (!w_i.xpos && w_i.ypos) t_nxt = HALF - phi;
    else if (w_i.xneg && !w_i.ypos) t_nxt = HALF + phi;
    else t_nxt = FULL - phi;
    rsum = {1'b0, root_i} + 1'b1;
  end

  always_comb begin
    if (t1_r < 0) tw_nxt = t1_r + FULL;
    else if (t1_r >= FULL) tw_nxt = t1_r - FULL;
    else tw_nxt = t1_r;
  end

  assign a_nxt = AW'(($unsigned(t2_r) + RND) >> SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= valid_i;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && valid_i) begin
      t1_r    <= t_nxt;
      zero1_r <= w_i.axz && w_i.ayz;
      last1_r <= w_i.last;
      rad1_r  <= RADIUS_W'(rsum >> 1);
    end
    if (rdy2 && v1_r) begin
      t2_r    <= tw_nxt;
      zero2_r <= zero1_r;
      last2_r <= last1_r;
      rad2_r  <= rad1_r;
    end
    if (rdy3 && v2_r) begin
      a3_r    <= a_nxt;
      zero3_r <= zero2_r;
      last3_r <= last2_r;
      rad3_r  <= rad2_r;
    end
    if (rdy4 && v3_r) begin
      if (zero3_r) ang4_r <= '0;
      else if (a3_r >= WRAP) ang4_r <= ANGLE_W'(a3_r - WRAP);
      else ang4_r <= ANGLE_W'(a3_r);
      last4_r <= last3_r;
      rad4_r  <= rad3_r;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cartesian_to_polar_core.sv @@
// cartesian_to_polar_core: pipelined cordic angle and digit-serial root radius
// throughput one request per cycle while out_if.ready holds; back-pressure stalls it
// each stage k holds a root digit if k < SQ_STEPS, a rotation if k < CORDIC_STAGES
// reset clears all valid bits, no clearing pass
// depends on c2p_pkg, c2p_in_if, c2p_out_if, c2p_front, c2p_stage, c2p_back
`default_nettype none
module cartesian_to_polar_core #(
  parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF,
  parameter int FRACTION_BITS = c2p_pkg::FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  c2p_in_if.sink    in_if,
  c2p_out_if.source out_if
);
  import c2p_pkg::*;

  localparam int SQ_STEPS = COORD_W + FRACTION_BITS + 1;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 3;
  localparam int NB       = (SQ_STEPS > CORDIC_STAGES) ? SQ_STEPS : CORDIC_STAGES;

  c2p_work_t         w   [NB+1];
  logic [REM_W-1:0]  rem [NB+1];
  logic [ROOT_W-1:0] root[NB+1];
  logic              vld [NB+1];
  logic              rdy [NB+1];

  assign rem[0]  = '0;
  assign root[0] = '0;

  c2p_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .work_o  (w[0]),
    .valid_o (vld[0]),
    .ready_i (rdy[0])
  );

  for (genvar k = 0; k < NB; k++) begin : g_stage
    c2p_stage #(
      .K             (k),
      .CORDIC_STAGES (CORDIC_STAGES),
      .FRACTION_BITS (FRACTION_BITS),
      .SQ_STEPS      (SQ_STEPS),
      .ROOT_W        (ROOT_W),
      .REM_W         (REM_W)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .w_i     (w[k]),
      .rem_i   (rem[k]),
      .root_i  (root[k]),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .w_o     (w[k+1]),
      .rem_o   (rem[k+1]),
      .root_o  (root[k+1]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  c2p_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .ROOT_W        (ROOT_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .w_i     (w[NB]),
    .root_i  (root[NB]),
    .valid_i (vld[NB]),
    .ready_o (rdy[NB]),
    .out_if  (out_if)
  );

`ifndef NO_ASSERTIONS
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.ready |-> in_if.ready)
    else $error("input stalled while output side is ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && FRACTION_BITS <= 16) |->
      (out_if.angle_deg < ANGLE_W'(64'd360 << FRACTION_BITS)))
    else $error("angle not below 360 degrees");
`endif

endmodule
`default_nettype wire
